/* design/psel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psel_pkg: shared types and constants for percentile selection
// Sample width, register indexes and the control bundle that the
// top level sends to every sorting cell.
// ----------------------------------------------------------------------------
package psel_pkg;

	localparam int SAMPLE_W         = 64;
	localparam int FRAC_W           = 16;
	localparam int COUNT_OUT_W      = 11;
	localparam int CFG_IDX_W        = 2;
	localparam int DEF_MAX_ELEMENTS = 1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIGNED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANK_FRACTION = 2'd1;

	localparam logic [FRAC_W-1:0] RANK_FRACTION_RST = 16'd32768;

	// per-cycle command to the cell row
	typedef struct packed {
		logic insert;   // place the broadcast sample
		logic shift;    // move every entry one cell toward cell 0
		logic clear;    // drop all entries
		logic sgn;      // two's complement ordering
	} psel_ctrl_t;

endpackage
`default_nettype wire

/* design/percentile_select_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percentile_select_top: rank selection over one image's samples
// Insertion-sorts samples into a row of cells, then after the last
// sample of an image returns the entry at floor(fraction * count).
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  sample    | sample_valid / sample_stall| sample_value, last_sample
//  result    | result_valid / result_stall| selected_value, element_count,
//            |                            | overflow_flag
//  cfg       | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  Sequence: a sample is taken every cycle while the row is loading; every
//  cell compares against the broadcast item and the row shifts open in that
//  same cycle. After the last item the rank index is formed (registered
//  multiply), then the row shifts toward cell 0 until the index is used up,
//  then cell 0 moves into the output register when that register is free.
//  The rank index stays below MAX_ELEMENTS.
//  Reset: control, count, drop flag, valid bits and registers return to
//  their reset values; entry payloads are undefined until written, and no
//  clearing pass is run.
//  Stalls: sample_stall is high from the cycle after the last item until
//  the result enters the output register; a held result only delays that
//  hand-off, and the next image loads while the result waits.
//
module percentile_select_top #(
	parameter int MAX_ELEMENTS = psel_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample channel
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [psel_pkg::SAMPLE_W-1:0]     sample_value,
	input  logic                              last_sample,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [psel_pkg::SAMPLE_W-1:0]     selected_value,
	output logic [psel_pkg::COUNT_OUT_W-1:0]  element_count,
	output logic                              overflow_flag,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psel_pkg::SAMPLE_W-1:0]     cfg_data
);
	import psel_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int PROD_W = FRAC_W + CNT_W;

	// sequencer states
	localparam logic [1:0] ST_LOAD = 2'd0;  // taking samples
	localparam logic [1:0] ST_MULT = 2'd1;  // forming rank index
	localparam logic [1:0] ST_SEEK = 2'd2;  // walking the row down to the rank

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic                dropped_q;
	logic [IDX_W-1:0]    idx_q;
	logic                sgn_q;
	logic [FRAC_W-1:0]   frac_q;

	logic                res_valid_q;
	logic [SAMPLE_W-1:0] res_value_q;
	logic [CNT_W-1:0]    res_count_q;
	logic                res_ovf_q;

	logic                in_acc;
	logic                out_acc;
	logic                full;
	logic                out_free;
	logic                handoff;
	logic [PROD_W-1:0]   product;
	logic [31:0]         cnt_ext;
	psel_ctrl_t          ctrl;

	// cell row
	logic [SAMPLE_W-1:0]     cell_value [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] cell_valid;
	logic [MAX_ELEMENTS-1:0] cell_gt;
	logic [MAX_ELEMENTS-1:0] cell_move;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != ST_LOAD);
	assign in_acc       = sample_valid && !sample_stall;
	assign out_acc      = res_valid_q && !result_stall;
	assign full         = (count_q == CNT_W'(MAX_ELEMENTS));
	assign out_free     = !res_valid_q || !result_stall;
	// rank reached and output register can take it
	assign handoff      = (state_q == ST_SEEK) && (idx_q == '0) && out_free;

	assign product = PROD_W'(frac_q) * PROD_W'(count_q);

	always_comb begin
		ctrl        = '0;
		ctrl.sgn    = sgn_q;
		ctrl.insert = in_acc && !full;
		ctrl.shift  = (state_q == ST_SEEK) && (idx_q != '0);
		ctrl.clear  = handoff;
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgn_q  <= 1'b1;
			frac_q <= RANK_FRACTION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_SIGNED: begin
					sgn_q <= cfg_data[0];
				end
				CFG_RANK_FRACTION: begin
					frac_q <= cfg_data[FRAC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer, fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (last_sample) begin
							state_q <= ST_MULT;
						end
					end
				end
				ST_MULT: begin
					// index < count, so it fits the cell address width
					idx_q   <= product[FRAC_W +: IDX_W];
					state_q <= ST_SEEK;
				end
				ST_SEEK: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
					end else if (out_free) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (handoff) begin
			res_valid_q <= 1'b1;
		end else if (out_acc) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			res_value_q <= cell_value[0];
			res_count_q <= count_q;
			res_ovf_q   <= dropped_q;
		end
	end

	assign cnt_ext        = 32'(res_count_q);
	assign result_valid   = res_valid_q;
	assign selected_value = res_value_q;
	assign element_count  = cnt_ext[COUNT_OUT_W-1:0];
	assign overflow_flag  = res_ovf_q;

	// which cells open up for the new sample
	psel_suffix #(
		.N(MAX_ELEMENTS)
	) u_suffix (
		.gt   (cell_gt),
		.move (cell_move)
	);

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic [SAMPLE_W-1:0] lv;
		logic [SAMPLE_W-1:0] rv;
		logic                lval;
		logic                lmov;

		if (i == 0) begin : g_head
			assign lv   = sample_value;
			assign lval = 1'b1;
			assign lmov = 1'b0;
		end else begin : g_body
			assign lv   = cell_value[i-1];
			assign lval = cell_valid[i-1];
			assign lmov = cell_move[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_tail
			assign rv = cell_value[i];
		end else begin : g_mid
			assign rv = cell_value[i+1];
		end

		psel_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (sample_value),
			.left_value  (lv),
			.left_valid  (lval),
			.left_move   (lmov),
			.right_value (rv),
			.move        (cell_move[i]),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i])
		);
	end

`ifndef NO_ASSERTIONS
	// a result only appears through the hand-off from the seek walk
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_SEEK)
		else $error("result raised outside seek hand-off");

	// a stored entry always sits in cell 0 while loading
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && count_q != '0) |-> cell_valid[0])
		else $error("count nonzero but head cell empty");

	// an accepted sample that fits grows the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !last_sample && !full) |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not advance on insert");
`endif

endmodule
`default_nettype wire

/* design/psel_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psel_cell: one entry of the insertion-sort row
// Holds one sample, compares it with the broadcast sample and takes
// either the new sample or its neighbor's entry.
// ----------------------------------------------------------------------------
module psel_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  psel_pkg::psel_ctrl_t           ctrl,
	input  logic [psel_pkg::SAMPLE_W-1:0]  new_value,
	input  logic [psel_pkg::SAMPLE_W-1:0]  left_value,
	input  logic                           left_valid,
	input  logic                           left_move,
	input  logic [psel_pkg::SAMPLE_W-1:0]  right_value,
	input  logic                           move,
	output logic [psel_pkg::SAMPLE_W-1:0]  value,
	output logic                           valid,
	output logic                           gt
);
	import psel_pkg::*;

	logic [SAMPLE_W-1:0] value_q;
	logic                valid_q;
	logic [SAMPLE_W-1:0] key_own;
	logic [SAMPLE_W-1:0] key_new;

	// signed order maps to unsigned order by flipping the sign bit
	assign key_own = {value_q[SAMPLE_W-1] ^ ctrl.sgn, value_q[SAMPLE_W-2:0]};
	assign key_new = {new_value[SAMPLE_W-1] ^ ctrl.sgn, new_value[SAMPLE_W-2:0]};

	// an empty cell counts as greater than anything
	assign gt = !valid_q || (key_own > key_new);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right_value;
		end else if (ctrl.insert && move) begin
			value_q <= left_move ? left_value : new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

/* design/psel_suffix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psel_suffix: suffix AND across the cell row
// Cell i moves when it and every cell above it compare greater; a
// log-depth prefix network forms that AND for all cells at once.
// ----------------------------------------------------------------------------
module psel_suffix #(
	parameter int N = psel_pkg::DEF_MAX_ELEMENTS
) (
	input  logic [N-1:0] gt,
	output logic [N-1:0] move
);
	localparam int LV = $clog2(N);

	logic [N-1:0] lvl [LV+1];

	assign lvl[0] = gt;

	for (genvar k = 0; k < LV; k++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i + (1 << k) < N) begin : g_and
				assign lvl[k+1][i] = lvl[k][i] & lvl[k][i + (1 << k)];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

	assign move = lvl[LV];

endmodule
`default_nettype wire
